// ----- rtl/odc_pkg.sv -----
package odc_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned DoyW   = 9;
  localparam int unsigned MonthW = 4;
  localparam int unsigned MdayW  = 5;
  localparam int unsigned WdayW  = 3;
  localparam int unsigned ErrW   = 2;

  localparam logic [YearW-1:0] YEAR_MAX    = YearW'(9999);
  localparam logic [DoyW-1:0]  DAYS_COMMON = DoyW'(365);

  // floor(x / 25) == (x * RECIP25) >> RECIP_SHIFT for every x below 4096
  localparam logic [10:0] RECIP25     = 11'd1311;
  localparam int unsigned RECIP_SHIFT = 15;
  localparam logic [4:0]  DIV25       = 5'd25;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE = 2'd0,
    ERR_YEAR = 2'd1,
    ERR_DAY  = 2'd2
  } odc_err_e;

  typedef struct packed {
    logic [YearW-1:0] year_value;
    logic [DoyW-1:0]  day_of_year;
  } odc_req_t;

  typedef struct packed {
    logic [MonthW-1:0] month_number;
    logic [MdayW-1:0]  day_of_month;
    logic [WdayW-1:0]  weekday;
    logic              leap_flag;
    logic [ErrW-1:0]   error_code;
  } odc_res_t;

  // Year unit to calendar unit: checked date and weekday day count
  typedef struct packed {
    logic             valid;
    logic             leap;
    odc_err_e         err;
    logic [DoyW-1:0]  doy;
    logic [YearW-1:0] day_sum;
  } odc_mid_t;

  // Days before the first of month m in a common year
  function automatic logic [DoyW-1:0] month_start(input logic [MonthW-1:0] m);
    logic [DoyW-1:0] s;
    case (m)
      4'd1:    s = 9'd0;
      4'd2:    s = 9'd31;
      4'd3:    s = 9'd59;
      4'd4:    s = 9'd90;
      4'd5:    s = 9'd120;
      4'd6:    s = 9'd151;
      4'd7:    s = 9'd181;
      4'd8:    s = 9'd212;
      4'd9:    s = 9'd243;
      4'd10:   s = 9'd273;
      4'd11:   s = 9'd304;
      4'd12:   s = 9'd334;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/odc_year_unit.sv -----
module odc_year_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  odc_pkg::odc_req_t req_i,
  output odc_pkg::odc_mid_t mid_o
);
  import odc_pkg::*;

  // Stage 1: quotients year/100 and year/400 by reciprocal multiply
  logic [22:0] prod100;
  logic [20:0] prod400;

  logic             s1_valid_q;
  logic [YearW-1:0] s1_year_q;
  logic [DoyW-1:0]  s1_doy_q;
  logic [7:0]       s1_q100_q, s1_q100_d;
  logic [5:0]       s1_q400_q, s1_q400_d;

  always_comb begin
    prod100   = 23'(req_i.year_value[13:2]) * 23'(RECIP25);
    prod400   = 21'(req_i.year_value[13:4]) * 21'(RECIP25);
    s1_q100_d = prod100[22:RECIP_SHIFT];
    s1_q400_d = prod400[20:RECIP_SHIFT];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_year_q <= req_i.year_value;
    s1_doy_q  <= req_i.day_of_year;
    s1_q100_q <= s1_q100_d;
    s1_q400_q <= s1_q400_d;
  end

  // Stage 2: leap rule, range checks, day count modulo-friendly sum
  logic [11:0]      rem100;
  logic [9:0]       rem400;
  logic             div100, div400, leap;
  logic [DoyW-1:0]  year_len;
  logic [YearW-1:0] prev_year;
  logic [7:0]       q100_prev;
  logic [5:0]       q400_prev;
  odc_err_e         err;
  odc_mid_t         mid_d, mid_q;

  always_comb begin
    rem100    = s1_year_q[13:2] - 12'(s1_q100_q * 12'(DIV25));
    rem400    = s1_year_q[13:4] - 10'(s1_q400_q * 10'(DIV25));
    div100    = (s1_year_q[1:0] == 2'd0) && (rem100 == 12'd0);
    div400    = (s1_year_q[3:0] == 4'd0) && (rem400 == 10'd0);
    leap      = (s1_year_q[1:0] == 2'd0) && (!div100 || div400);
    year_len  = DAYS_COMMON + DoyW'(leap);

    if (s1_year_q == '0 || s1_year_q > YEAR_MAX) begin
      err = ERR_YEAR;
    end else if (s1_doy_q == '0 || s1_doy_q > year_len) begin
      err = ERR_DAY;
    end else begin
      err = ERR_NONE;
    end

    // Quotients of (year - 1) follow from those of year
    prev_year = s1_year_q - YearW'(1);
    q100_prev = s1_q100_q - 8'(div100);
    q400_prev = s1_q400_q - 6'(div400);

    // 365 == 1 mod 7, so the weekday is this sum mod 7
    mid_d.valid   = s1_valid_q;
    mid_d.leap    = leap;
    mid_d.err     = err;
    mid_d.doy     = s1_doy_q;
    mid_d.day_sum = prev_year + YearW'(prev_year[13:2]) - YearW'(q100_prev)
                  + YearW'(q400_prev) + YearW'(s1_doy_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= '0;
    end else begin
      mid_q <= mid_d;
    end
  end

  assign mid_o = mid_q;

endmodule

// ----- rtl/odc_cal_unit.sv -----
module odc_cal_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  odc_pkg::odc_mid_t mid_i,
  output logic              done_o,
  output odc_pkg::odc_res_t res_o
);
  import odc_pkg::*;

  // Stage 3: month search and octal fold of the day count
  logic [MonthW-1:0] month_d, s3_month_q;
  logic [DoyW-1:0]   start_d, s3_start_q;
  logic [DoyW-1:0]   cand;
  logic [4:0]        fold_d, s3_fold_q;
  logic              s3_valid_q, s3_leap_q;
  odc_err_e          s3_err_q;
  logic [DoyW-1:0]   s3_doy_q;

  always_comb begin
    month_d = '0;
    start_d = '0;
    cand    = '0;
    for (int m = 1; m <= 12; m++) begin
      cand = month_start(MonthW'(m)) + ((m >= 3) ? DoyW'(mid_i.leap) : '0);
      if (mid_i.doy > cand) begin
        month_d = MonthW'(m);
        start_d = cand;
      end
    end
    // 8 == 1 mod 7: sum the octal digits
    fold_d = 5'(mid_i.day_sum[2:0]) + 5'(mid_i.day_sum[5:3]) + 5'(mid_i.day_sum[8:6])
           + 5'(mid_i.day_sum[11:9]) + 5'(mid_i.day_sum[13:12]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= mid_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_month_q <= month_d;
    s3_start_q <= start_d;
    s3_fold_q  <= fold_d;
    s3_leap_q  <= mid_i.leap;
    s3_err_q   <= mid_i.err;
    s3_doy_q   <= mid_i.doy;
  end

  // Stage 4: day of month, final mod 7, zero fields on error
  logic [3:0] wsum;
  logic [2:0] wday;
  logic [DoyW-1:0] mday_full;
  odc_res_t   res_d, res_q;
  logic       done_q;

  always_comb begin
    wsum      = 4'(s3_fold_q[4:3]) + 4'(s3_fold_q[2:0]);
    wday      = (wsum >= 4'd7) ? 3'(wsum - 4'd7) : wsum[2:0];
    mday_full = s3_doy_q - s3_start_q;

    res_d.leap_flag  = s3_leap_q;
    res_d.error_code = s3_err_q;
    if (s3_err_q == ERR_NONE) begin
      res_d.month_number = s3_month_q;
      res_d.day_of_month = mday_full[MdayW-1:0];
      res_d.weekday      = wday;
    end else begin
      res_d.month_number = '0;
      res_d.day_of_month = '0;
      res_d.weekday      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ----- rtl/ordinal_date_to_calendar_top.sv -----
// Ordinal date to Gregorian calendar converter. Present a year and a day of the
// year on req_i with start high; since busy never rises, a request is taken on
// every cycle that start is high, one per clock. Each request yields exactly one
// result on res_o, flagged by done_o for a single cycle, in request order. The
// receiver has no way to hold results off, so it must capture res_o whenever
// done_o is high. A request passes through four register stages: reciprocal
// multiply for the /100 and /400 quotients, leap rule and range checks with the
// day-count sum, month search with a mod-7 fold, and the final day-of-month and
// weekday with the output register.
// Errors zero the month, day and weekday fields; leap_flag is always reported.
module ordinal_date_to_calendar_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  odc_pkg::odc_req_t req_i,
  output logic              done_o,
  output odc_pkg::odc_res_t res_o
);
  import odc_pkg::*;

  odc_mid_t mid;
  logic     accept;

  // Fully pipelined and never stalled: accept every request
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Stages 1-2: year arithmetic, leap rule, range checks
  odc_year_unit u_year (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .req_i   (req_i),
    .mid_o   (mid)
  );

  // Stages 3-4: month, day of month, weekday, output register
  odc_cal_unit u_cal (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mid_i  (mid),
    .done_o (done_o),
    .res_o  (res_o)
  );

endmodule
